### design/sorted_multiset_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Sorted multiset table assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SORTED_MULTISET_TABLE_UNIT_DEFINES_SVH
`define SORTED_MULTISET_TABLE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted table check failed");

// The consequent must hold in the cycle after the antecedent.
`define SMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted table check failed");

`endif

### design/smt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted multiset table package
// Sizes, operation and status codes, and the result bundle of the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smt_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    logic signed [31:0] read_value;
    logic [CNT_W-1:0]  count;
  } smt_res_t;

endpackage

### design/smt_ram.sv
// ----------------------------------------------------------------------------
// Sorted multiset table storage
// Element memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smt_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [smt_pkg::ADDR_W-1:0] waddr,
  input  logic [31:0]                wdata,
  input  logic                       re,
  input  logic [smt_pkg::ADDR_W-1:0] raddr,
  output logic [31:0]                rdata
);
  import smt_pkg::*;

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/smt_seq.sv
// ----------------------------------------------------------------------------
// Sorted multiset table sequencer
// Walks the element memory entry by entry with an ordering and an equality
// comparator, shifting entries to open or close a gap; keeps the element count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smt_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             opcode,
  input  logic signed [31:0]     value,
  input  logic [3:0]             rank,
  output logic                   res_valid,
  input  logic                   res_ready,
  output smt_pkg::smt_res_t      res
);
  import smt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_INS_PUT, S_DEL_RD, S_DEL_CMP,
    S_SHF_RD, S_SHF_WR, S_RD_RD, S_RD_DATA, S_FINISH
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   count;
  logic signed [31:0] val;
  logic [1:0]         res_status;
  logic signed [31:0] res_read_value;

  logic [CNT_W-1:0]   idx_m1;
  logic [CNT_W-1:0]   idx_p1;
  logic [CNT_W-1:0]   idx_p2;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [31:0]        wdata;
  logic               re;
  logic [ADDR_W-1:0]  raddr;
  logic [31:0]        rdata;
  logic               not_smaller;
  logic               equal;

  smt_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign idx_m1      = idx - 1'b1;
  assign idx_p1      = idx + 1'b1;
  assign idx_p2      = idx_p1 + 1'b1;
  assign not_smaller = $signed(rdata) >= val;
  assign equal       = rdata == val;
  assign in_ready    = state == S_IDLE;
  assign res_valid   = state == S_FINISH;
  assign res         = '{status: res_status, read_value: res_read_value, count: count};

  always_comb begin
    we    = 1'b0;
    waddr = idx[ADDR_W-1:0];
    wdata = val;
    re    = 1'b0;
    raddr = idx[ADDR_W-1:0];
    case (state)
      S_INS_RD: begin
        re    = 1'b1;
        raddr = idx_m1[ADDR_W-1:0];
      end
      S_INS_CMP: begin
        we    = 1'b1;
        wdata = not_smaller ? rdata : val;
      end
      S_INS_PUT: begin
        we    = 1'b1;
        waddr = '0;
      end
      S_DEL_RD, S_RD_RD: begin
        re = 1'b1;
      end
      S_SHF_RD: begin
        re    = 1'b1;
        raddr = idx_p1[ADDR_W-1:0];
      end
      S_SHF_WR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            val            <= value;
            res_read_value <= '0;
            case (opcode)
              OP_INSERT: begin
                if (32'(count) >= 32'(DEPTH)) begin
                  res_status <= ST_FULL;
                  state      <= S_FINISH;
                end else if (count == '0) begin
                  res_status <= ST_OK;
                  state      <= S_INS_PUT;
                end else begin
                  res_status <= ST_OK;
                  idx        <= count;
                  state      <= S_INS_RD;
                end
              end
              OP_DELETE: begin
                if (count == '0) begin
                  res_status <= ST_NOT_FOUND;
                  state      <= S_FINISH;
                end else begin
                  res_status <= ST_OK;
                  idx        <= '0;
                  state      <= S_DEL_RD;
                end
              end
              OP_READ: begin
                if (32'(rank) >= 32'(count)) begin
                  res_status <= ST_RANGE;
                  state      <= S_FINISH;
                end else begin
                  res_status <= ST_OK;
                  idx        <= CNT_W'(rank);
                  state      <= S_RD_RD;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_FINISH;
              end
            endcase
          end
        end
        S_INS_RD: begin
          state <= S_INS_CMP;
        end
        S_INS_CMP: begin
          if (not_smaller) begin
            idx   <= idx_m1;
            state <= (idx_m1 == '0) ? S_INS_PUT : S_INS_RD;
          end else begin
            count <= count + 1'b1;
            state <= S_FINISH;
          end
        end
        S_INS_PUT: begin
          count <= count + 1'b1;
          state <= S_FINISH;
        end
        S_DEL_RD: begin
          state <= S_DEL_CMP;
        end
        S_DEL_CMP: begin
          if (equal) begin
            if (idx_p1 == count) begin
              count <= count - 1'b1;
              state <= S_FINISH;
            end else begin
              state <= S_SHF_RD;
            end
          end else if (idx_p1 == count) begin
            res_status <= ST_NOT_FOUND;
            state      <= S_FINISH;
          end else begin
            idx   <= idx_p1;
            state <= S_DEL_RD;
          end
        end
        S_SHF_RD: begin
          state <= S_SHF_WR;
        end
        S_SHF_WR: begin
          idx <= idx_p1;
          if (idx_p2 == count) begin
            count <= count - 1'b1;
            state <= S_FINISH;
          end else begin
            state <= S_SHF_RD;
          end
        end
        S_RD_RD: begin
          state <= S_RD_DATA;
        end
        S_RD_DATA: begin
          res_read_value <= rdata;
          state          <= S_FINISH;
        end
        S_FINISH: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/sorted_multiset_table_unit.sv
// ----------------------------------------------------------------------------
// Sorted multiset table unit
// Keeps up to DEPTH signed 32-bit values in ascending order, duplicates kept.
//
// The input channel (in_valid, in_ready) carries an opcode, a value and a
// rank: insert in order, delete one matching copy, or read at a rank. Each
// input transfer gives exactly one result on the output channel (out_valid,
// out_ready) with a status, the read value and the element count after the
// operation.
// One operation is handled at a time by a sequencer that steps an ordering
// and an equality comparator over the element memory, reading each entry
// visited through the registered memory read port.
// The result sits in an output register, so the next input transfer is
// taken while an earlier result still waits; when the receiver stalls with
// a result held, a second finished result waits in the sequencer and no
// further input is accepted.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sorted_multiset_table_unit_defines.svh"

module sorted_multiset_table_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] value,
  input  logic [3:0]         rank,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [31:0] read_value,
  output logic [4:0]         element_count
);
  import smt_pkg::*;

  logic     res_valid;
  logic     res_ready;
  smt_res_t res;

  smt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .value     (value),
    .rank      (rank),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      status        <= res.status;
      read_value    <= res.read_value;
      element_count <= 5'(res.count);
    end
  end

  `SMT_ASSERT_SAME(a_count_bound, out_valid, 32'(element_count) <= 32'(DEPTH))
  `SMT_ASSERT_SAME(a_full_count, out_valid && status == ST_FULL, 32'(element_count) == 32'(DEPTH))
  `SMT_ASSERT_SAME(a_value_zero, out_valid && status != ST_OK, read_value == 32'sd0)
  `SMT_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Sorted multiset table unit testbench
// Drives insert, delete, read and unused operations through the valid/ready
// input channel and checks every result transfer against a shadow copy of the
// sorted table or a typed row's expected result. A short directed table covers
// the extremes, an empty table, duplicates and a full table. A long random run
// follows with fill, drain and balanced phases, idling randomly on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import smt_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_OPS = 1550;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic               typed;
    logic [1:0]         op;
    logic signed [31:0] operand;
    logic [3:0]         pos;
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [4:0]         count;
  } probe_row_t;

  localparam logic signed [31:0] S_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S_MIN = 32'sh80000000;

  localparam probe_row_t DIRECTED [25] = '{
    '{1'b1, OP_READ,   32'sd0,          4'd0,  ST_RANGE,     32'sd0, 5'd0},
    '{1'b1, OP_DELETE, 32'sd5,          4'd0,  ST_NOT_FOUND, 32'sd0, 5'd0},
    '{1'b1, OP_UNUSED, 32'shFFFFFFFF,   4'd15, ST_OK,        32'sd0, 5'd0},
    '{1'b1, OP_INSERT, S_MAX,           4'd0,  ST_OK,        32'sd0, 5'd1},
    '{1'b1, OP_INSERT, S_MIN,           4'd0,  ST_OK,        32'sd0, 5'd2},
    '{1'b1, OP_READ,   32'sd0,          4'd0,  ST_OK,        S_MIN,  5'd2},
    '{1'b1, OP_INSERT, 32'sd0,          4'd0,  ST_OK,        32'sd0, 5'd3},
    '{1'b1, OP_INSERT, 32'sd0,          4'd0,  ST_OK,        32'sd0, 5'd4},
    '{1'b1, OP_DELETE, 32'sd0,          4'd0,  ST_OK,        32'sd0, 5'd3},
    '{1'b1, OP_READ,   32'sd0,          4'd3,  ST_RANGE,     32'sd0, 5'd3},
    '{1'b0, OP_INSERT, -32'sd1,         4'd0,  ST_OK,        32'sd0, 5'd0},
    '{1'b0, OP_INSERT, 32'sd1,          4'd0,  ST_OK,        32'sd0, 5'd0},
    '{1'b0, OP_INSERT, 32'sh55555555,   4'd0,  ST_OK,        32'sd0, 5'd0},
    '{1'b0, OP_INSERT, 32'shAAAAAAAA,   4'd0,  ST_OK,        32'sd0, 5'd0},
    '{1'b0, OP_INSERT, 32'sh7FFFFFFE,   4'd0,  ST_OK,        32'sd0, 5'd0},
    '{1'b0, OP_INSERT, 32'sh80000001,   4'd0,  ST_OK,        32'sd0, 5'd0},
    '{1'b0, OP_INSERT, 32'sd100,        4'd0,  ST_OK,        32'sd0, 5'd0},
    '{1'b0, OP_INSERT, -32'sd100,       4'd0,  ST_OK,        32'sd0, 5'd0},
    '{1'b0, OP_INSERT, 32'sd0,          4'd0,  ST_OK,        32'sd0, 5'd0},
    '{1'b0, OP_INSERT, S_MAX,           4'd0,  ST_OK,        32'sd0, 5'd0},
    '{1'b0, OP_INSERT, S_MIN,           4'd0,  ST_OK,        32'sd0, 5'd0},
    '{1'b0, OP_INSERT, 32'sd42,         4'd0,  ST_OK,        32'sd0, 5'd0},
    '{1'b1, OP_INSERT, -32'sd42,        4'd0,  ST_OK,        32'sd0, 5'd16},
    '{1'b1, OP_INSERT, 32'sd7,          4'd0,  ST_FULL,      32'sd0, 5'd16},
    '{1'b1, OP_READ,   32'sd0,          4'd15, ST_OK,        S_MAX,  5'd16}
  };

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         opcode;
  logic signed [31:0] value;
  logic [3:0]         rank;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [4:0]         element_count;

  logic signed [31:0] shadow_store [DEPTH];
  int                 shadow_count;
  smt_res_t           pending_results [$];
  int                 failures;
  logic               steady_stretch;

  sorted_multiset_table_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .value         (value),
    .rank          (rank),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .read_value    (read_value),
    .element_count (element_count)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_INSERT;
    value = '0;
    rank = '0;
    out_ready = 1'b0;
    steady_stretch = 1'b0;
    failures = 0;
    shadow_count = 0;
  end

  always #10 clk = ~clk;

  function automatic smt_res_t apply_to_shadow(input logic [1:0] op,
                                               input logic signed [31:0] v,
                                               input logic [3:0] r);
    smt_res_t res;
    int       i;
    int       slot;
    logic     found;
    res = '0;
    found = 1'b0;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot = shadow_count;
          for (i = 0; i < shadow_count; i++) begin
            if (shadow_store[i] >= v) begin
              slot = i;
              break;
            end
          end
          for (i = shadow_count; i > slot; i--) shadow_store[i] = shadow_store[i-1];
          shadow_store[slot] = v;
          shadow_count++;
        end
      end
      OP_DELETE: begin
        slot = 0;
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_store[i] == v) begin
            slot = i;
            found = 1'b1;
            break;
          end
        end
        if (!found) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (i = slot; i + 1 < shadow_count; i++) shadow_store[i] = shadow_store[i+1];
          shadow_count--;
        end
      end
      OP_READ: begin
        if (int'(r) >= shadow_count) res.status = ST_RANGE;
        else res.read_value = shadow_store[r];
      end
      default: ;
    endcase
    res.count = shadow_count[CNT_W-1:0];
    return res;
  endfunction

  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 35) return $signed(32'($urandom_range(8))) - 32'sd4;
    if (sel < 45 && shadow_count > 0) return shadow_store[$urandom_range(shadow_count - 1)];
    if (sel < 50) return sel[0] ? S_MAX : S_MIN;
    return $urandom;
  endfunction

  // Presents one operation and returns at the edge where the transfer takes
  // place, with the predicted result already queued.
  task automatic issue_op(input logic [1:0] op, input logic signed [31:0] v,
                          input logic [3:0] r, input logic typed,
                          input smt_res_t typed_res);
    smt_res_t res;
    if (!steady_stretch && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    value <= v;
    rank <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = apply_to_shadow(op, v, r);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (steady_stretch) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 17);
  end

  always @(posedge clk) begin
    smt_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no operation outstanding");
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          failures++;
        end
        if (read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, read_value);
          failures++;
        end
        if (element_count !== want.count) begin
          $error("element_count: expected %0d, got %0d", want.count, element_count);
          failures++;
        end
      end
    end
  end

  initial begin
    smt_res_t           typed_res;
    logic [1:0]         op;
    logic signed [31:0] v;
    logic [3:0]         r;
    int                 mix;
    int                 ins_pct;
    int                 del_pct;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[k]) begin
      typed_res.status = DIRECTED[k].status;
      typed_res.read_value = DIRECTED[k].read_value;
      typed_res.count = DIRECTED[k].count;
      issue_op(DIRECTED[k].op, DIRECTED[k].operand, DIRECTED[k].pos,
               DIRECTED[k].typed, typed_res);
    end
    wait_for_results();

    typed_res = '0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      steady_stretch = (n >= 300 && n < 600);
      case ((n / 120) % 3)
        0: begin ins_pct = 55; del_pct = 20; end
        1: begin ins_pct = 20; del_pct = 55; end
        default: begin ins_pct = 36; del_pct = 36; end
      endcase
      mix = $urandom_range(99);
      r = 4'($urandom_range(15));
      v = pick_value();
      if (mix < ins_pct) begin
        op = OP_INSERT;
      end else if (mix < ins_pct + del_pct) begin
        op = OP_DELETE;
        if (shadow_count > 0 && $urandom_range(99) < 75)
          v = shadow_store[$urandom_range(shadow_count - 1)];
      end else if (mix < 97) begin
        op = OP_READ;
        if ($urandom_range(99) < 70)
          r = 4'($urandom_range(shadow_count > 15 ? 15 : shadow_count));
      end else begin
        op = OP_UNUSED;
      end
      issue_op(op, v, r, 1'b0, typed_res);
      if (n == RANDOM_OPS / 2) wait_for_results();
    end
    steady_stretch = 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
